[sv/jacobi_7point_stencil_residual_top_defines.svh]
// Assertion macros shared by the stencil block.
`ifndef JACOBI_7POINT_STENCIL_RESIDUAL_TOP_DEFINES_SVH
`define JACOBI_7POINT_STENCIL_RESIDUAL_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JC7_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JC7_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/jc7_pkg.sv]
// Shared types and constants of the 7-point stencil block.
package jc7_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned RES_W     = 64;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned PROD_W    = 50;
  localparam int unsigned SZ_XY_W   = 7;
  localparam int unsigned SZ_Z_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // one sixth in Q0.16, kept positive in a signed 15-bit word
  localparam logic signed [14:0] SIXTH_Q16 = 15'sd10923;
  localparam logic [PROD_W-1:0]  RND_HALF  = PROD_W'(32768);

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic CMD_NODE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // window reads issued for one result
  localparam logic [2:0] SEL_OLD = 3'd0;
  localparam logic [2:0] SEL_XP  = 3'd1;
  localparam logic [2:0] SEL_XM  = 3'd2;
  localparam logic [2:0] SEL_YP  = 3'd3;
  localparam logic [2:0] SEL_YM  = 3'd4;
  localparam logic [2:0] SEL_ZP  = 3'd5;
  localparam logic [2:0] SEL_ZM  = 3'd6;

  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       mul_en;
    logic       rnd_en;
    logic       sq_en;
    logic       acc_en;
    logic       adv;
  } jc7_cmd_t;

  typedef struct packed {
    logic settled;
    logic node_ok;
    logic node_emit;
    logic flush_ok;
    logic interior;
    logic out_full;
    logic at_last;
    logic pos_zero;
  } jc7_sts_t;

endpackage

[sv/jacobi_7point_stencil_residual_top.sv]
// Top level of the 3D 7-point Jacobi stencil with residual.
//
// Input channel (in_valid_i/in_ready_o): one transaction per node value in
// raster order (x fastest), cmd_i low; cmd_i high is a flush that drains one
// pending result once the whole volume has arrived.
// Output channel (out_valid_o/out_ready_i): one transaction per node, same
// order, with the running residual; last_o marks the final node.
// Results trail the inputs by one plane plus one row plus one node.
// A node that releases no result is taken without further steps. For a result,
// the single read port of the window RAM fetches the centre, and for an
// interior node the six neighbours too, one per cycle; the last read data is
// then taken, an interior result is multiplied, rounded, squared and
// accumulated, and the result is loaded into the output register. No
// transaction is taken meanwhile. Reset clears positions and the residual and
// sets all sizes to 64; input is accepted only once the size pipeline settles after reset or a size write.
// A result waits in the output register while the receiver stalls; further
// nodes are still taken until the next result needs that register.
`include "jacobi_7point_stencil_residual_top_defines.svh"

module jacobi_7point_stencil_residual_top import jc7_pkg::*; #(
  parameter int unsigned MAX_ROW      = 64,
  parameter int unsigned MAX_ROWS     = 64,
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic signed [VAL_W-1:0] node_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] new_value_o,
  output logic [RES_W-1:0]        residual_sum_o,
  output logic                    last_o
);

  jc7_cmd_t cmd;
  jc7_sts_t sts;

  // sequencer: accept, then drive the read and arithmetic steps
  jc7_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: sizes, window store, arithmetic and output register
  jc7_dp #(
    .MAX_ROW      (MAX_ROW),
    .MAX_ROWS     (MAX_ROWS),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .node_value_i   (node_value_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .new_value_o    (new_value_o),
    .residual_sum_o (residual_sum_o),
    .last_o         (last_o)
  );

  // a result is loaded only into a free output register
  `JC7_ASSERT_IMP(a_adv_out_free, cmd.adv, !out_valid_o, "result loaded over a pending one")
  // window writes come only from an accepted node transaction
  `JC7_ASSERT_IMP(a_wr_accepted, cmd.wr_en, in_valid_i && in_ready_o && (cmd_i == CMD_NODE),
    "window written without a node transaction")
  // the final result of a volume restarts both positions
  `JC7_ASSERT_NXT(a_last_clears, cmd.adv && sts.at_last, sts.pos_zero,
    "positions not cleared after the last result")

endmodule

[sv/jc7_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module jc7_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/jc7_ctrl.sv]
// Sequencer: accepts transactions and steps one result through the datapath.
module jc7_ctrl import jc7_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     cmd_i,
  output logic     in_ready_o,
  input  jc7_sts_t sts_i,
  output jc7_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;
  localparam logic [2:0] ST_SQ   = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.settled;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (cmd_i == CMD_NODE) begin
            if (sts_i.node_ok) begin
              cmd_o.wr_en = 1'b1;
              if (sts_i.node_emit) begin
                state_d = ST_RD;
                step_d  = SEL_OLD;
              end
            end
          end else if (sts_i.flush_ok) begin
            state_d = ST_RD;
            step_d  = SEL_OLD;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = step_q;
        if ((step_q == SEL_ZM) || !sts_i.interior) begin
          state_d = ST_WAIT;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_WAIT: state_d = sts_i.interior ? ST_MUL : ST_OUT;
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        state_d     = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!sts_i.out_full) begin
          cmd_o.adv = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SEL_OLD;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[sv/jc7_dp.sv]
// Datapath: sizes, positions, window store, stencil arithmetic, output register.
module jc7_dp import jc7_pkg::*; #(
  parameter int unsigned MAX_ROW      = 64,
  parameter int unsigned MAX_ROWS     = 64,
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic signed [VAL_W-1:0] node_value_i,
  input  logic                  out_ready_i,
  input  jc7_cmd_t              cmd_i,
  output jc7_sts_t              sts_o,
  output logic                  out_valid_o,
  output logic signed [VAL_W-1:0] new_value_o,
  output logic [RES_W-1:0]      residual_sum_o,
  output logic                  last_o
);

  localparam int unsigned X_W    = $clog2(MAX_ROW + 1);
  localparam int unsigned Y_W    = $clog2(MAX_ROWS + 1);
  localparam int unsigned PL_W   = X_W + Y_W;
  localparam int unsigned RAW_PW = PL_W + SZ_Z_W;
  localparam int unsigned POS_W  = (RAW_PW > 32) ? 32 : RAW_PW;
  localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : a + ADDR_W'(1);
  endfunction

  // configuration
  logic [SZ_XY_W-1:0] size_x_q, size_y_q;
  logic [SZ_Z_W-1:0]  size_z_q;
  logic               cfg_hit;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      cfg_hit = cfg_idx_i inside {REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SZ_XY_W'(64);
      size_y_q <= SZ_XY_W'(64);
      size_z_q <= SZ_Z_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIZE_X: size_x_q <= cfg_data_i[SZ_XY_W-1:0];
        REG_SIZE_Y: size_y_q <= cfg_data_i[SZ_XY_W-1:0];
        REG_SIZE_Z: size_z_q <= cfg_data_i[SZ_Z_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes, then plane, then total and lag, each step registered
  logic [31:0]       sx_ext, sy_ext;
  logic [X_W-1:0]    dx_c, dx_q;
  logic [Y_W-1:0]    dy_c, dy_q;
  logic [SZ_Z_W-1:0] dz_c, dz_q;
  logic [PL_W-1:0]   plane_q;
  logic [POS_W-1:0]  total_q, lag_q;
  logic [1:0]        settle_q;

  always_comb begin
    sx_ext = 32'(size_x_q);
    sy_ext = 32'(size_y_q);
    dx_c   = X_W'((sx_ext < 32'd3) ? 32'd3 : ((sx_ext > MAX_ROW) ? MAX_ROW : sx_ext));
    dy_c   = Y_W'((sy_ext < 32'd3) ? 32'd3 : ((sy_ext > MAX_ROWS) ? MAX_ROWS : sy_ext));
    dz_c   = (size_z_q < SZ_Z_W'(3)) ? SZ_Z_W'(3) : size_z_q;
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_c;
    dy_q    <= dy_c;
    dz_q    <= dz_c;
    plane_q <= PL_W'(dx_c) * PL_W'(dy_c);
    total_q <= POS_W'(RAW_PW'(plane_q) * RAW_PW'(dz_q));
    lag_q   <= POS_W'(plane_q) + POS_W'(dx_q) + POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
    end else if (cfg_hit) begin
      settle_q <= '0;
    end else begin
      settle_q <= {settle_q[0], 1'b1};
    end
  end

  // positions and window pointers
  logic [POS_W-1:0]  in_pos_q, out_pos_q, dx_pos, plane_pos;
  logic [ADDR_W-1:0] in_addr_q, o_addr_q;
  logic [ADDR_W-1:0] xp_addr_q, yp_addr_q, zp_addr_q;
  logic [ADDR_W-1:0] xm_addr_q, ym_addr_q, zm_addr_q;
  logic [X_W-1:0]    x_q;
  logic [Y_W-1:0]    y_q;
  logic [SZ_Z_W-1:0] z_q;
  logic              at_last, clear, interior;

  assign dx_pos    = POS_W'(dx_q);
  assign plane_pos = POS_W'(plane_q);
  assign at_last   = out_pos_q == (total_q - POS_W'(1));
  assign clear     = cfg_hit || (cmd_i.adv && at_last);
  assign interior  = (x_q != '0) && (x_q <= dx_q - X_W'(2)) &&
                     (y_q != '0) && (y_q <= dy_q - Y_W'(2)) &&
                     (z_q != '0) && (z_q <= dz_q - SZ_Z_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      out_pos_q <= '0;
      in_addr_q <= '0;
      o_addr_q  <= '0;
      xm_addr_q <= '0;
      ym_addr_q <= '0;
      zm_addr_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
    end else if (clear) begin
      in_pos_q  <= '0;
      out_pos_q <= '0;
      in_addr_q <= '0;
      o_addr_q  <= '0;
      xm_addr_q <= '0;
      ym_addr_q <= '0;
      zm_addr_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
    end else begin
      if (cmd_i.wr_en) begin
        in_pos_q  <= in_pos_q + POS_W'(1);
        in_addr_q <= wrap_inc(in_addr_q);
      end
      if (cmd_i.adv) begin
        out_pos_q <= out_pos_q + POS_W'(1);
        o_addr_q  <= wrap_inc(o_addr_q);
        // trailing pointers start moving once the node behind exists
        if (out_pos_q >= POS_W'(1)) xm_addr_q <= wrap_inc(xm_addr_q);
        if (out_pos_q >= dx_pos)    ym_addr_q <= wrap_inc(ym_addr_q);
        if (out_pos_q >= plane_pos) zm_addr_q <= wrap_inc(zm_addr_q);
        if (x_q == dx_q - X_W'(1)) begin
          x_q <= '0;
          if (y_q == dy_q - Y_W'(1)) begin
            y_q <= '0;
            z_q <= z_q + SZ_Z_W'(1);
          end else begin
            y_q <= y_q + Y_W'(1);
          end
        end else begin
          x_q <= x_q + X_W'(1);
        end
      end
    end
  end

  // leading pointers: take the write address of the matching node, then advance
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      if (in_pos_q == POS_W'(1)) xp_addr_q <= in_addr_q;
      if (in_pos_q == dx_pos)    yp_addr_q <= in_addr_q;
      if (in_pos_q == plane_pos) zp_addr_q <= in_addr_q;
    end else if (cmd_i.adv) begin
      xp_addr_q <= wrap_inc(xp_addr_q);
      yp_addr_q <= wrap_inc(yp_addr_q);
      zp_addr_q <= wrap_inc(zp_addr_q);
    end
  end

  // window store
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_data;

  always_comb begin
    case (cmd_i.rd_sel)
      SEL_OLD: rd_addr = o_addr_q;
      SEL_XP:  rd_addr = xp_addr_q;
      SEL_XM:  rd_addr = xm_addr_q;
      SEL_YP:  rd_addr = yp_addr_q;
      SEL_YM:  rd_addr = ym_addr_q;
      SEL_ZP:  rd_addr = zp_addr_q;
      SEL_ZM:  rd_addr = zm_addr_q;
      default: rd_addr = o_addr_q;
    endcase
  end

  jc7_ram #(
    .WIDTH (VAL_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (in_addr_q),
    .wdata_i (node_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // arithmetic
  logic                     rvld_q;
  logic [2:0]               rsel_q;
  logic signed [VAL_W-1:0]  old_q, nv_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [PROD_W-1:0] prod_q, rnd_sum, rnd_sh;
  logic signed [VAL_W:0]    diff;
  logic [VAL_W-1:0]         nv_d, mag_q;
  logic [RES_W-1:0]         sq_q, acc_q, res_q;
  logic [RES_W:0]           acc_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= cmd_i.rd_en;
    end
  end

  always_comb begin
    rnd_sum = prod_q + $signed(RND_HALF);
    rnd_sh  = rnd_sum >>> 16;
    // saturate when the bits above the sign do not all match it
    if ((rnd_sh[PROD_W-1:VAL_W-1] == '0) || (rnd_sh[PROD_W-1:VAL_W-1] == '1)) begin
      nv_d = rnd_sh[VAL_W-1:0];
    end else begin
      nv_d = rnd_sh[PROD_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    diff    = (VAL_W+1)'($signed(nv_d)) - (VAL_W+1)'(old_q);
    acc_sum = (RES_W+1)'(res_q) + (RES_W+1)'(sq_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rsel_q <= cmd_i.rd_sel;
    end
    if (rvld_q) begin
      if (rsel_q == SEL_OLD) begin
        old_q <= $signed(rd_data);
        sum_q <= '0;
      end else begin
        sum_q <= sum_q + SUM_W'($signed(rd_data));
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(SIXTH_Q16);
    end
    if (cmd_i.rnd_en) begin
      nv_q  <= $signed(nv_d);
      mag_q <= VAL_W'(diff[VAL_W] ? -diff : diff);
    end
    if (cmd_i.sq_en) begin
      sq_q <= RES_W'(mag_q) * RES_W'(mag_q);
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_sum[RES_W] ? '1 : acc_sum[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (clear) begin
      res_q <= '0;
    end else if (cmd_i.adv && interior) begin
      res_q <= acc_q;
    end
  end

  // output register
  logic                    out_valid_q, last_q;
  logic signed [VAL_W-1:0] new_value_q;
  logic [RES_W-1:0]        residual_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.adv) begin
      new_value_q <= interior ? nv_q : old_q;
      residual_q  <= interior ? acc_q : res_q;
      last_q      <= at_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_value_o    = new_value_q;
  assign residual_sum_o = residual_q;
  assign last_o         = last_q;

  always_comb begin
    sts_o           = '0;
    sts_o.settled   = settle_q[1];
    sts_o.node_ok   = in_pos_q < total_q;
    sts_o.node_emit = (in_pos_q + POS_W'(1) - out_pos_q) > lag_q;
    sts_o.flush_ok  = (in_pos_q == total_q) && (out_pos_q < total_q);
    sts_o.interior  = interior;
    sts_o.out_full  = out_valid_q;
    sts_o.at_last   = at_last;
    sts_o.pos_zero  = (in_pos_q == '0) && (out_pos_q == '0);
  end

endmodule
